[rtl/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// Life grid package
// Shared sizes, types and operation codes for the life grid generation step.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

  // Side of the square grid in cells; one memory row holds one grid row.
  localparam int GRID_SIDE = 64;

  // Fixed width of the col_x and row_y fields.
  localparam int CoordW = 6;

  // Row address and column index width.
  localparam int RowW = $clog2(GRID_SIDE);

  // Sweep counter width, wide enough to hold GRID_SIDE itself.
  localparam int CntW = $clog2(GRID_SIDE + 1);

  // Neighbor count width: up to eight live neighbors.
  localparam int SumW = $clog2(8 + 1);

  typedef logic [GRID_SIDE-1:0] row_t;
  typedef logic [RowW-1:0]      addr_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [CoordW-1:0]    coord_t;
  typedef logic [SumW-1:0]      sum_t;

  localparam cnt_t SweepLast = cnt_t'(GRID_SIDE);

  // B3/S23: birth on three neighbors, survival on two or three.
  localparam sum_t BirthCount   = sum_t'(3);
  localparam sum_t SurviveCount = sum_t'(2);

  // Operation codes; the unused code behaves as a read.
  typedef enum logic [1:0] {
    FUNC_TOGGLE = 2'd0,
    FUNC_STEP   = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

endpackage

`default_nettype wire

[rtl/lgs_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered in the cycle after the read.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/lgs_rule.sv]
// ----------------------------------------------------------------------------
// Life row evaluator
// Computes the next generation of one row from the old row above, the old
// row itself and the old row below, with dead cells beyond the edges.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_rule (
  input  wire lgs_pkg::row_t above_i,
  input  wire lgs_pkg::row_t cur_i,
  input  wire lgs_pkg::row_t below_i,
  output lgs_pkg::row_t      next_o
);

  // Rows padded with a dead cell on each side.
  logic [lgs_pkg::GRID_SIDE+1:0] pad_a;
  logic [lgs_pkg::GRID_SIDE+1:0] pad_c;
  logic [lgs_pkg::GRID_SIDE+1:0] pad_b;
  lgs_pkg::sum_t                 sum;

  assign pad_a = {1'b0, above_i, 1'b0};
  assign pad_c = {1'b0, cur_i, 1'b0};
  assign pad_b = {1'b0, below_i, 1'b0};

  always_comb begin
    next_o = '0;
    sum    = '0;
    for (int c = 0; c < lgs_pkg::GRID_SIDE; c++) begin
      sum = lgs_pkg::sum_t'(pad_a[c]) + lgs_pkg::sum_t'(pad_a[c+1])
          + lgs_pkg::sum_t'(pad_a[c+2]) + lgs_pkg::sum_t'(pad_c[c])
          + lgs_pkg::sum_t'(pad_c[c+2]) + lgs_pkg::sum_t'(pad_b[c])
          + lgs_pkg::sum_t'(pad_b[c+1]) + lgs_pkg::sum_t'(pad_b[c+2]);
      next_o[c] = (sum == lgs_pkg::BirthCount)
               || (pad_c[c+1] && (sum == lgs_pkg::SurviveCount));
    end
  end

endmodule

`default_nettype wire

[rtl/life_grid_generation_step.sv]
// ----------------------------------------------------------------------------
// Life grid generation step
// Conway B3/S23 grid of one-bit cells held row by row in a RAM.
// ----------------------------------------------------------------------------
// Usage: each input beat carries an operation (func_i), a column (col_x_i)
// and a row (row_y_i). Toggle flips the addressed cell, read leaves the grid
// alone, and step advances the whole grid one generation with dead cells
// beyond the edges. Every input beat yields exactly one output beat, alive_o,
// which is the addressed cell after the operation; it is 0 when the address
// lies outside the grid.
// Flow: toggle and read pass through a RAM read, a modify and write back,
// and a result state before the next acceptance. A step sweeps the grid:
// it reads one row per cycle from the single read port and writes each
// finished row once the row below it has arrived, keeping the old rows
// above and at the current position in registers. The result beat is then
// loaded into the output register as soon as that register is free.
// Reset: every grid row is marked empty by a per-row valid bit, so the grid
// reads as all dead at once, with no clearing pass.
// Stalls: the output register holds its beat until taken; the next input
// beat is accepted while it waits, but its own result waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] func_i,
  input  wire logic [5:0] col_x_i,
  input  wire logic [5:0] row_y_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            alive_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_SWEEP  = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Item being worked on.
  logic [1:0]            func_q, func_d;
  lgs_pkg::coord_t       x_q, x_d;
  lgs_pkg::coord_t       y_q, y_d;
  logic                  inside_q, inside_d;
  logic                  res_q, res_d;

  // Sweep window: old row above and old current row.
  lgs_pkg::cnt_t         cnt_q, cnt_d;
  lgs_pkg::row_t         above_q, above_d;
  lgs_pkg::row_t         cur_q, cur_d;

  // Row valid bits stand in for clearing the RAM at reset.
  lgs_pkg::row_t         row_valid_q, row_valid_d;
  logic                  rd_valid_q, rd_valid_d;

  logic                  out_valid_q, out_valid_d;
  logic                  alive_q, alive_d;

  // RAM ports.
  logic                  wr_en;
  lgs_pkg::addr_t        wr_addr;
  lgs_pkg::row_t         wr_data;
  logic                  rd_en;
  lgs_pkg::addr_t        rd_addr;
  lgs_pkg::row_t         ram_rd_data;
  lgs_pkg::row_t         rd_row;

  lgs_pkg::row_t         below_row;
  lgs_pkg::row_t         next_row;
  lgs_pkg::addr_t        col_idx;
  logic                  accept;
  logic                  in_inside;
  logic                  out_free;

  lgs_ram #(
    .WIDTH (lgs_pkg::GRID_SIDE),
    .DEPTH (lgs_pkg::GRID_SIDE)
  ) u_grid_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd_data)
  );

  lgs_rule u_rule (
    .above_i (above_q),
    .cur_i   (cur_q),
    .below_i (below_row),
    .next_o  (next_row)
  );

  // A row that was never written reads as all dead.
  assign rd_row    = rd_valid_q ? ram_rd_data : '0;
  // Past the last row the row below lies outside the grid.
  assign below_row = (cnt_q == lgs_pkg::SweepLast) ? '0 : rd_row;
  assign col_idx   = lgs_pkg::addr_t'(x_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_inside  = (int'(col_x_i) < lgs_pkg::GRID_SIDE)
                   && (int'(row_y_i) < lgs_pkg::GRID_SIDE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    x_d         = x_q;
    y_d         = y_q;
    inside_d    = inside_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    above_d     = above_q;
    cur_d       = cur_q;
    row_valid_d = row_valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    alive_d     = alive_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_row;
    rd_en       = 1'b0;
    rd_addr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d   = func_i;
          x_d      = col_x_i;
          y_d      = row_y_i;
          inside_d = in_inside;
          res_d    = 1'b0;
          if (func_i == lgs_pkg::FUNC_STEP) begin
            // Start the sweep with row 0; the row above it is dead.
            rd_en   = 1'b1;
            rd_addr = '0;
            cnt_d   = '0;
            above_d = '0;
            state_d = S_SWEEP;
          end else begin
            rd_en   = in_inside;
            rd_addr = lgs_pkg::addr_t'(row_y_i);
            state_d = S_ACCESS;
          end
        end
      end

      S_ACCESS: begin
        // Read-modify-write of a single row; only a toggle writes back.
        wr_en   = (func_q == lgs_pkg::FUNC_TOGGLE) && inside_q;
        wr_addr = lgs_pkg::addr_t'(y_q);
        wr_data = rd_row ^ (lgs_pkg::row_t'(1) << col_idx);
        res_d   = inside_q && (rd_row[col_idx] ^ (func_q == lgs_pkg::FUNC_TOGGLE));
        state_d = S_DONE;
      end

      S_SWEEP: begin
        // In sweep cycle n the old row n arrives; row n-1 is written.
        if (cnt_q == '0) begin
          cur_d = rd_row;
        end else begin
          wr_en   = 1'b1;
          wr_addr = lgs_pkg::addr_t'(cnt_q - 1'b1);
          wr_data = next_row;
          above_d = cur_q;
          cur_d   = rd_row;
          if (inside_q && (wr_addr == lgs_pkg::addr_t'(y_q))) begin
            res_d = next_row[col_idx];
          end
        end
        if (int'(cnt_q) + 1 < lgs_pkg::GRID_SIDE) begin
          rd_en   = 1'b1;
          rd_addr = lgs_pkg::addr_t'(cnt_q + 1'b1);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lgs_pkg::SweepLast) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          alive_d     = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (wr_en) begin
      row_valid_d[wr_addr] = 1'b1;
    end
    rd_valid_d = rd_en ? row_valid_q[rd_addr] : rd_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_valid_q <= row_valid_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    x_q      <= x_d;
    y_q      <= y_d;
    inside_q <= inside_d;
    res_q    <= res_d;
    above_q  <= above_d;
    cur_q    <= cur_d;
    alive_q  <= alive_d;
  end

  assign out_valid_o = out_valid_q;
  assign alive_o     = alive_q;

  // The sweep never reads the row it is writing in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("grid RAM read and write hit the same row");

  // The sweep counter stops at the last row.
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (cnt_q <= lgs_pkg::SweepLast))
    else $error("sweep counter ran past the grid");

  // A toggle or read goes straight to its row access.
  a_access_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i != lgs_pkg::FUNC_STEP)) |=> (state_q == S_ACCESS))
    else $error("toggle or read did not start its row access");

  // An address outside the grid always reports a dead cell.
  a_outside_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !inside_q) |-> !res_q)
    else $error("result for an address outside the grid is live");

endmodule

`default_nettype wire
